// File: rtl/pcza_pkg.sv
// Package for the z-axis point alignment block: shared types and constants.
package pcza_pkg;

	localparam int TRIG_FRAC = 30;
	localparam int TRIG_W    = 32;

	// Commands from the controller to the datapath
	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_ROOT,
		CMD_DIV,
		CMD_MUL,
		CMD_FINISH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    sel;   // which divide or which multiply pair
	} ctrl_t;

	typedef struct packed {
		logic step_done;
		logic degen;
	} stat_t;

endpackage

// File: rtl/pcza_if.sv
// Valid/ready channel interface carrying one transaction payload.
interface pcza_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pcza_dp.sv
// Datapath: operand registers, iterative root and divider, shared multiplier, rotation state.
module pcza_dp #(
	parameter int CW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcza_pkg::ctrl_t     ctrl,
	output pcza_pkg::stat_t     stat,
	input  logic                in_mode,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [CW-1:0] in_z,
	output logic [3*CW+1:0]     res
);
	localparam int SW  = 2*CW;                       // sum of squares
	localparam int RW  = CW + 1;                     // root width
	localparam int NW  = CW + pcza_pkg::TRIG_FRAC + 1; // dividend width
	localparam int RCW = $clog2(SW/2 + 2);
	localparam int DCW = $clog2(NW + 2);
	localparam int PW  = CW + pcza_pkg::TRIG_W;      // product width
	localparam logic signed [CW:0] CMAX = {2'b00, {(CW-1){1'b1}}};
	localparam logic signed [CW:0] CMIN = -CMAX - 1;
	localparam logic signed [pcza_pkg::TRIG_W-1:0] ONE =
		pcza_pkg::TRIG_W'(1) << pcza_pkg::TRIG_FRAC;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [CW-1:0]        ax_q, ay_q;
	logic                 mode_q;
	logic signed [pcza_pkg::TRIG_W-1:0] cos_q, sin_q;
	logic signed [CW:0]   zoff_q;
	// root
	logic [SW-1:0]  sq_q;
	logic [SW-1:0]  rrem_q;
	logic [RW-1:0]  rroot_q;
	logic [RCW-1:0] rcnt_q;
	logic [RW-1:0]  d_q;
	// divide
	logic [NW-1:0]  dnum_q;
	logic [NW-1:0]  drem_q;
	logic [NW-1:0]  dquo_q;
	logic [DCW-1:0] dcnt_q;
	// multiply
	logic signed [PW:0] acc_q;
	logic signed [CW+1:0] ox_q, oy_q;
	logic mul_phase_q;
	logic step_done;
	logic degen_q;

	// square magnitudes, root digit step, divide bit step
	logic [SW-1:0]  sqx, sqy;
	logic [RW+1:0]  trial;
	logic [SW-1:0]  rem_sh;
	logic [NW-1:0]  dsh;
	logic [NW-1:0]  quo_r;
	logic signed [PW-1:0] p;
	logic signed [PW:0] sum;
	logic [PW:0] msum;
	logic signed [CW+1:0] un;

	assign sqx    = SW'(ax_q) * SW'(ax_q);
	assign sqy    = SW'(ay_q) * SW'(ay_q);
	assign rem_sh = {rrem_q[SW-3:0], sq_q[SW-1 -: 2]};
	assign trial  = {rroot_q, 2'b01};
	assign dsh    = {drem_q[NW-2:0], dnum_q[NW-1]};
	assign quo_r  = dquo_q + NW'(drem_q >= NW'(d_q) - (NW'(d_q) >> 1) ? 1 : 0);

	// one product per cycle: sine/cosine by x/y
	always_comb begin
		logic signed [pcza_pkg::TRIG_W-1:0] a;
		logic signed [CW-1:0] b;
		a = (ctrl.sel ^ mul_phase_q) ? sin_q : cos_q;
		b = mul_phase_q ? y_q : x_q;
		if (ctrl.sel && !mul_phase_q) a = sin_q;
		if (ctrl.sel && mul_phase_q) a = cos_q;
		if (!ctrl.sel && mul_phase_q) a = -sin_q;
		if (!ctrl.sel && !mul_phase_q) a = cos_q;
		p = PW'(a) * PW'(b);
	end
	assign sum  = acc_q + (PW+1)'(p);
	assign msum = sum[PW] ? (PW+1)'(-sum) : (PW+1)'(sum);
	always_comb begin
		logic [PW:0] m;
		m = (msum + ((PW+1)'(1) << (pcza_pkg::TRIG_FRAC-1))) >> pcza_pkg::TRIG_FRAC;
		un = sum[PW] ? -(CW+2)'(m) : (CW+2)'(m);
	end

	// last cycle of the current step
	always_comb begin
		case (ctrl.op)
			pcza_pkg::CMD_ROOT:   step_done = (rcnt_q == '0);
			pcza_pkg::CMD_DIV:    step_done = (dcnt_q == '0);
			pcza_pkg::CMD_MUL:    step_done = mul_phase_q;
			pcza_pkg::CMD_FINISH: step_done = 1'b1;
			default:              step_done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= ONE;
			sin_q <= '0;
			zoff_q <= '0;
			mul_phase_q <= 1'b0;
			degen_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				pcza_pkg::CMD_LOAD: begin
					x_q <= in_x; y_q <= in_y; z_q <= in_z; mode_q <= in_mode;
					ax_q <= in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
					ay_q <= in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
					acc_q <= '0; mul_phase_q <= 1'b0;
					rcnt_q <= RCW'(SW/2 + 1);
					rrem_q <= '0; rroot_q <= '0;
					degen_q <= 1'b0;
				end
				pcza_pkg::CMD_ROOT: begin
					if (rcnt_q == RCW'(SW/2 + 1)) begin
						sq_q <= sqx + sqy;
						rcnt_q <= rcnt_q - 1'b1;
					end else if (rcnt_q != '0) begin
						if (rem_sh >= SW'(trial)) begin
							rrem_q <= rem_sh - SW'(trial);
							rroot_q <= {rroot_q[RW-2:0], 1'b1};
						end else begin
							rrem_q <= rem_sh;
							rroot_q <= {rroot_q[RW-2:0], 1'b0};
						end
						sq_q <= sq_q << 2;
						rcnt_q <= rcnt_q - 1'b1;
					end else begin
						d_q <= rroot_q + RW'(rrem_q > SW'(rroot_q) ? 1 : 0);
						dcnt_q <= DCW'(NW + 1);
					end
				end
				pcza_pkg::CMD_DIV: begin
					if (dcnt_q == DCW'(NW + 1)) begin
						dnum_q <= NW'(ctrl.sel ? ax_q : ay_q) << pcza_pkg::TRIG_FRAC;
						drem_q <= '0; dquo_q <= '0;
						dcnt_q <= dcnt_q - 1'b1;
					end else if (dcnt_q != '0) begin
						if (dsh >= NW'(d_q)) begin
							drem_q <= dsh - NW'(d_q);
							dquo_q <= {dquo_q[NW-2:0], 1'b1};
						end else begin
							drem_q <= dsh;
							dquo_q <= {dquo_q[NW-2:0], 1'b0};
						end
						dnum_q <= dnum_q << 1;
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						// quotient complete: round half up on the remainder
						if (d_q == '0) begin
							cos_q <= ONE; sin_q <= '0; degen_q <= 1'b1;
						end else if (ctrl.sel) begin
							sin_q <= x_q[CW-1] ? -pcza_pkg::TRIG_W'(quo_r)
								: pcza_pkg::TRIG_W'(quo_r);
						end else begin
							cos_q <= y_q[CW-1] ? -pcza_pkg::TRIG_W'(quo_r)
								: pcza_pkg::TRIG_W'(quo_r);
						end
						dcnt_q <= DCW'(NW + 1);
					end
				end
				pcza_pkg::CMD_MUL: begin
					if (!mul_phase_q) begin
						acc_q <= sum; mul_phase_q <= 1'b1;
					end else begin
						acc_q <= '0; mul_phase_q <= 1'b0;
						if (ctrl.sel) oy_q <= un; else ox_q <= un;
					end
				end
				pcza_pkg::CMD_FINISH: begin
					if (!mode_q) zoff_q <= -(CW+1)'(z_q);
				end
				default: ;
			endcase
		end
	end

	assign stat.step_done = step_done;
	assign stat.degen = (d_q == '0);

	// result formatting with saturation
	always_comb begin
		logic signed [CW+1:0] rx, ry, rz;
		logic cx, cy, cz;
		rz = (CW+2)'(z_q) + (CW+2)'(zoff_q);
		rx = ox_q; ry = oy_q;
		cx = rx > (CW+2)'(CMAX) || rx < (CW+2)'(CMIN);
		cy = ry > (CW+2)'(CMAX) || ry < (CW+2)'(CMIN);
		cz = rz > (CW+2)'(CMAX) || rz < (CW+2)'(CMIN);
		if (!mode_q) begin
			res = {CW'(0),
				(d_q > RW'(CMAX)) ? CW'(CMAX) : CW'(d_q),
				CW'(0), degen_q, d_q > RW'(CMAX)};
		end else begin
			res = {cx ? (rx[CW+1] ? CW'(CMIN) : CW'(CMAX)) : CW'(rx),
				cy ? (ry[CW+1] ? CW'(CMIN) : CW'(CMAX)) : CW'(ry),
				cz ? (rz[CW+1] ? CW'(CMIN) : CW'(CMAX)) : CW'(rz),
				1'b0, cx | cy | cz};
		end
	end
endmodule

// File: rtl/pcza_ctrl.sv
// Controller: sequences load, root, divides, multiplies and the output register.
module pcza_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_mode,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_load,
	output pcza_pkg::ctrl_t ctrl,
	input  pcza_pkg::stat_t stat
);
	typedef enum logic [2:0] {S_IDLE, S_ROOT, S_DIVC, S_DIVS, S_MULX, S_MULY, S_FIN, S_OUT}
		state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign out_load = (state_q == S_OUT) && !out_valid;

	always_comb begin
		ctrl.sel = 1'b0;
		unique case (state_q)
			S_IDLE: ctrl.op = (in_valid && in_ready) ? pcza_pkg::CMD_LOAD : pcza_pkg::CMD_IDLE;
			S_ROOT: ctrl.op = pcza_pkg::CMD_ROOT;
			S_DIVC: ctrl.op = pcza_pkg::CMD_DIV;
			S_DIVS: begin ctrl.op = pcza_pkg::CMD_DIV; ctrl.sel = 1'b1; end
			S_MULX: ctrl.op = pcza_pkg::CMD_MUL;
			S_MULY: begin ctrl.op = pcza_pkg::CMD_MUL; ctrl.sel = 1'b1; end
			S_FIN:  ctrl.op = pcza_pkg::CMD_FINISH;
			default: ctrl.op = pcza_pkg::CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= in_mode ? S_MULX : S_ROOT;
				end
				S_ROOT: if (stat.step_done) state_q <= S_DIVC;
				S_DIVC: if (stat.step_done) state_q <= stat.degen ? S_FIN : S_DIVS;
				S_DIVS: if (stat.step_done) state_q <= S_FIN;
				S_MULX: if (stat.step_done) state_q <= S_MULY;
				S_MULY: if (stat.step_done) state_q <= S_FIN;
				S_FIN:  if (stat.step_done) state_q <= S_OUT;
				S_OUT: if (!out_valid) begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/point_cloud_z_axis_align.sv
// Point cloud alignment about the z axis: one result transaction per input transaction.
// Input channel carries {mode, in_x, in_y, in_z}; output carries
// {out_x, out_y, out_z, degenerate, clipped}, all valid/ready.
// A reference transaction (mode 0) takes a square root of x*x+y*y one digit a
// cycle and then two restoring divides one bit a cycle; a reference on the z
// axis (x and y both zero) skips the second divide. A point transaction uses
// the single shared multiplier four times, one product a cycle.
// The result sits in an output register until the receiver takes it; the
// next transaction is accepted once the result is taken.
// Reset restores the identity rotation and a zero z offset.
module point_cloud_z_axis_align #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	pcza_if.sink   in_ch,
	pcza_if.source out_ch
);
	localparam int RESW = 3*COORD_WIDTH + 2 + 0*FRAC_BITS;

	pcza_pkg::ctrl_t ctrl;
	pcza_pkg::stat_t stat;
	logic [RESW-1:0] res;
	logic [RESW-1:0] res_q;
	logic out_load;
	logic out_valid;

	pcza_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_mode(in_ch.data[3*COORD_WIDTH]),
		.out_valid(out_valid), .out_ready(out_ch.ready),
		.out_load(out_load), .ctrl(ctrl), .stat(stat)
	);

	pcza_dp #(.CW(COORD_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.in_mode(in_ch.data[3*COORD_WIDTH]),
		.in_x(in_ch.data[3*COORD_WIDTH-1 -: COORD_WIDTH]),
		.in_y(in_ch.data[2*COORD_WIDTH-1 -: COORD_WIDTH]),
		.in_z(in_ch.data[COORD_WIDTH-1:0]),
		.res(res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (out_load) res_q <= res;
	end

	assign out_ch.valid = out_valid;
	assign out_ch.data  = res_q;
endmodule

// File: test/point_cloud_z_axis_align_tb.sv
// Self-checking testbench for the z-axis point alignment block.
`timescale 1ns / 1ps

module point_cloud_z_axis_align_tb;

	localparam int CW       = 32;
	localparam int IN_W     = 1 + 3 * CW;
	localparam int OUT_W    = 3 * CW + 2;
	localparam int WD_LIMIT = 20000;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;
	localparam logic MODE_REF = 1'b0;
	localparam logic MODE_PT  = 1'b1;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          degen;
		logic          clip;
	} align_res_t;

	logic clk;
	logic arst_n;

	pcza_if #(.W(IN_W))  in_ch ();
	pcza_if #(.W(OUT_W)) out_ch ();

	point_cloud_z_axis_align #(.COORD_WIDTH(CW), .FRAC_BITS(16)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Predictor state
	longint rot_cos, rot_sin, z_shift;
	align_res_t pending_res[$];
	int  err_cnt;
	int  idle_cycles;
	bit  hold_sink;
	bit  sink_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint umag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clamp(longint v, ref bit c);
		if (v > CMAX) begin
			c = 1'b1;
			return CMAX;
		end
		if (v < CMIN) begin
			c = 1'b1;
			return CMIN;
		end
		return v;
	endfunction

	// Rounded square root, ties up
	function automatic longint isqrt_rnd(longint unsigned s);
		longint unsigned rem, r, b;
		rem = s;
		r = 0;
		b = 64'd1 << 62;
		while (b > rem && b != 0) b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (rem > r) r += 1;
		return longint'(r);
	endfunction

	function automatic longint trig_ratio(longint num, longint d);
		longint unsigned q;
		q = ((unsigned'(umag(num)) << pcza_pkg::TRIG_FRAC) + (d >> 1)) / d;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	// Remove the Q2.30 scale, rounding half away from zero
	function automatic longint descale(logic signed [95:0] v);
		logic [95:0] m;
		m = v < 0 ? -v : v;
		m = (m + (96'd1 << (pcza_pkg::TRIG_FRAC - 1))) >> pcza_pkg::TRIG_FRAC;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic align_res_t predict_align(logic mode, logic [CW-1:0] ix,
			logic [CW-1:0] iy, logic [CW-1:0] iz);
		align_res_t r;
		longint x, y, z, d, ox, oy, oz;
		logic signed [95:0] sx, sy;
		bit c;
		x = longint'(signed'(ix));
		y = longint'(signed'(iy));
		z = longint'(signed'(iz));
		c = 1'b0;
		r.degen = 1'b0;
		if (mode == MODE_REF) begin
			d = isqrt_rnd(unsigned'(umag(x) * umag(x))
				+ unsigned'(umag(y) * umag(y)));
			z_shift = -z;
			ox = 0;
			oz = 0;
			if (d == 0) begin
				rot_cos = 64'sd1 << pcza_pkg::TRIG_FRAC;
				rot_sin = 0;
				r.degen = 1'b1;
				oy = 0;
			end else begin
				rot_cos = trig_ratio(y, d);
				rot_sin = trig_ratio(x, d);
				oy = clamp(d, c);
			end
		end else begin
			sx = 96'(rot_cos) * 96'(x) - 96'(rot_sin) * 96'(y);
			sy = 96'(rot_sin) * 96'(x) + 96'(rot_cos) * 96'(y);
			ox = clamp(descale(sx), c);
			oy = clamp(descale(sy), c);
			oz = clamp(z + z_shift, c);
		end
		r.x = ox[CW-1:0];
		r.y = oy[CW-1:0];
		r.z = oz[CW-1:0];
		r.clip = c;
		return r;
	endfunction

	// Send one transaction, with a random gap first
	task automatic send_item(logic mode, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [CW-1:0] z);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
		repeat (gap) @(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data  <= {mode, x, y, z};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_res.push_back(predict_align(mode, x, y, z));
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			1: return $urandom_range(0, 2000) - 1000;
			2: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
			default: return $urandom;
		endcase
	endfunction

	// Extremes, degenerate reference, identity before any reference
	task automatic test_directed();
		send_item(MODE_PT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send_item(MODE_PT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_item(MODE_REF, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000);
		send_item(MODE_PT, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000);
		send_item(MODE_PT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_item(MODE_REF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(MODE_PT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(MODE_PT, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
		send_item(MODE_REF, 32'h0, 32'h0, 32'h7fff_ffff);
		send_item(MODE_PT, 32'h1234_5678, 32'hfedc_ba98, 32'h8000_0000);
		send_item(MODE_REF, 32'h0000_0001, 32'h0000_0000, 32'h0);
		send_item(MODE_PT, 32'h0001_0000, 32'h0, 32'h0);
		send_item(MODE_REF, 32'h0000_0001, 32'hffff_ffff, 32'h0);
		send_item(MODE_PT, 32'hffff_0000, 32'h0001_0000, 32'hffff_ffff);
		send_item(MODE_REF, 32'h0, 32'h8000_0000, 32'h0);
		send_item(MODE_PT, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
		send_item(MODE_REF, 32'hffff_ffff, 32'h0, 32'h0);
		send_item(MODE_PT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	// Mostly point transactions, with occasional new references
	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(MODE_REF, ($urandom_range(0, 15) == 0) ? 32'h0 : rand_coord(),
					($urandom_range(0, 15) == 0) ? 32'h0 : rand_coord(), rand_coord());
			else
				send_item(MODE_PT, rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_sink = 1'b1;
		fork
			test_random(12);
			begin
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
		join
	endtask

	// Sender pauses until the pipeline is empty
	task automatic test_pause();
		drain_results();
		repeat ($urandom_range(1, 4)) test_random(1);
		drain_results();
	endtask

	// Output ready: low while hold_sink is set, otherwise high, with random stalls when sink_gaps is set
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink) out_ch.ready <= 1'b0;
			else if (!sink_gaps) out_ch.ready <= 1'b1;
			else if ($urandom_range(0, 19) == 0) out_ch.ready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) out_ch.ready <= $urandom_range(0, 1);
			else out_ch.ready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		align_res_t got, exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				err_cnt++;
			end else begin
				exp_r = pending_res.pop_front();
				if (got.x !== exp_r.x)
					$display("%0t: out_x exp %h got %h", $time, exp_r.x, got.x);
				if (got.y !== exp_r.y)
					$display("%0t: out_y exp %h got %h", $time, exp_r.y, got.y);
				if (got.z !== exp_r.z)
					$display("%0t: out_z exp %h got %h", $time, exp_r.z, got.z);
				if (got.degen !== exp_r.degen)
					$display("%0t: degenerate exp %b got %b", $time, exp_r.degen, got.degen);
				if (got.clip !== exp_r.clip)
					$display("%0t: clipped exp %b got %b", $time, exp_r.clip, got.clip);
				if (got !== exp_r) err_cnt++;
			end
		end
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		err_cnt = 0;
		idle_cycles = 0;
		hold_sink = 1'b0;
		sink_gaps = 1'b1;
		rot_cos = 64'sd1 << pcza_pkg::TRIG_FRAC;
		rot_sin = 0;
		z_shift = 0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_pause();
		test_random(400);
		sink_gaps = 1'b0;
		test_random(100);
		sink_gaps = 1'b1;
		test_random(380);
		drain_results();
		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
